[rtl/core/twr_pkg.sv]
package twr_pkg;

  localparam int MAX_RING_ENTRIES_DEF = 256;
  localparam int IDX_LIMIT            = 256;

  localparam int IDX_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int TYPE_W  = 6;
  localparam int BYTES_W = 17;
  localparam int KIND_W  = TYPE_W + 1;

  localparam logic [SIZE_W-1:0] RING_SIZE_RST = 9'd256;
  localparam logic [SIZE_W-1:0] RING_SIZE_MIN = 9'd2;

  localparam logic [TYPE_W-1:0] TYPE_NORMAL     = 6'd1;
  localparam logic [TYPE_W-1:0] TYPE_LINK       = 6'd6;
  localparam logic [TYPE_W-1:0] TYPE_EVENT_DATA = 6'd7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_WALK   = 2'd1,
    FUNC_DEQ    = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  trb_type;
    logic               chain;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  function automatic entry_t decode_trb(input logic [WORD_W-1:0] ctrl,
                                        input logic [WORD_W-1:0] stat);
    entry_t e;
    e.trb_type = ctrl[15:10];
    e.chain    = ctrl[4];
    e.bytes    = stat[BYTES_W-1:0];
    return e;
  endfunction

endpackage

[rtl/core/twr_in_if.sv]
interface twr_in_if import twr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  trb_index;
  logic [WORD_W-1:0] control_word;
  logic [WORD_W-1:0] status_word;
  logic [IDX_W-1:0]  enqueue_index;
  logic [WORD_W-1:0] shortfall_in;

  modport source (output valid, func, trb_index, control_word, status_word,
                  enqueue_index, shortfall_in, input ready);
  modport sink   (input valid, func, trb_index, control_word, status_word,
                  enqueue_index, shortfall_in, output ready);
endinterface

[rtl/core/twr_out_if.sv]
interface twr_out_if import twr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  result_index;
  logic [WORD_W-1:0] shortfall_out;

  modport source (output valid, result_index, shortfall_out, input ready);
  modport sink   (input valid, result_index, shortfall_out, output ready);
endinterface

[rtl/core/twr_cfg_if.sv]
interface twr_cfg_if import twr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] ring_size;

  modport source (output valid, ring_size, input ready);
  modport sink   (input valid, ring_size, output ready);
endinterface

[rtl/core/twr_ring_mem.sv]
module twr_ring_mem import twr_pkg::*; #(
  parameter int DEPTH = MAX_RING_ENTRIES_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/transfer_ring_td_walker_top.sv]
// Transfer ring walker: descriptors live in one single-port-read synchronous RAM, so the
// block handles one item at a time. A descriptor write goes to the RAM when it is
// accepted. A walk reads the start descriptor, then follows chained descriptors (at most
// the ring size) in ST_WALK, since the RAM read port delivers one descriptor per cycle; a
// walk that starts at the enqueue index reads no descriptor. A next-dequeue query reads
// one descriptor in ST_DEQ, or none when the answer needs no descriptor read. Results pass
// through a registered output stage. ring_size is clamped to 2..min(MAX_RING_ENTRIES, 256)
// and must only be written while the block is idle.
module transfer_ring_td_walker_top import twr_pkg::*; #(
  parameter int MAX_RING_ENTRIES = MAX_RING_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  twr_in_if.sink   in_ch,
  twr_out_if.source out_ch,
  twr_cfg_if.sink  cfg_ch
);

  localparam int CAP = (MAX_RING_ENTRIES < IDX_LIMIT) ? MAX_RING_ENTRIES : IDX_LIMIT;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DEQ,
    ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   ring_size_r, ring_size_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [WORD_W-1:0]   out_sf_r, out_sf_nxt;

  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    enq_r, enq_nxt;
  logic [WORD_W-1:0]   sf_r, sf_nxt;
  logic [SIZE_W-1:0]   steps_r, steps_nxt;
  logic                add_r, add_nxt;
  logic                oob_r, oob_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [WORD_W-1:0]   res_sf_r, res_sf_nxt;

  mem_req_t            mreq;
  entry_t              mem_rdata;

  logic [SIZE_W-1:0]   size_eff;
  logic [SIZE_W-1:0]   size_m1;
  logic [TYPE_W-1:0]   rd_type;
  logic                rd_chain;
  logic [BYTES_W-1:0]  rd_bytes;
  logic [WORD_W-1:0]   sf_cur;
  logic [SIZE_W-1:0]   walk_nxt9;
  logic [IDX_W-1:0]    walk_nxt;
  logic                walk_cont;
  logic [SIZE_W-1:0]   in_nxt9;
  logic                in_acc;
  logic                out_free;

  twr_ring_mem #(.DEPTH(CAP)) u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (ring_size_r < RING_SIZE_MIN) begin
      size_eff = RING_SIZE_MIN;
    end else if (ring_size_r > SIZE_CAP) begin
      size_eff = SIZE_CAP;
    end else begin
      size_eff = ring_size_r;
    end
  end
  assign size_m1 = size_eff - 9'd1;

  // slots beyond the store read as zero
  assign rd_type  = oob_r ? '0 : mem_rdata.trb_type;
  assign rd_chain = oob_r ? 1'b0 : mem_rdata.chain;
  assign rd_bytes = oob_r ? '0 : mem_rdata.bytes;

  assign sf_cur = sf_r + ((add_r && rd_type == TYPE_NORMAL) ?
                          WORD_W'(rd_bytes) : '0);
  assign walk_cont = (rd_type != TYPE_EVENT_DATA) && rd_chain && (steps_r < size_eff);
  assign walk_nxt9 = {1'b0, cur_r} + 9'd1;
  assign walk_nxt  = (rd_type == TYPE_LINK || walk_nxt9 >= size_m1) ? '0
                                                                     : walk_nxt9[IDX_W-1:0];
  assign in_nxt9 = {1'b0, in_ch.trb_index} + 9'd1;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    ring_size_nxt = ring_size_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_sf_nxt    = out_sf_r;
    cur_nxt       = cur_r;
    enq_nxt       = enq_r;
    sf_nxt        = sf_r;
    steps_nxt     = steps_r;
    add_nxt       = add_r;
    oob_nxt       = oob_r;
    res_idx_nxt   = res_idx_r;
    res_sf_nxt    = res_sf_r;
    mreq          = '0;

    if (cfg_ch.valid) begin
      ring_size_nxt = cfg_ch.ring_size;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_ch.func))
            FUNC_WRITE: begin
              mreq.we    = ({1'b0, in_ch.trb_index} < SIZE_CAP);
              mreq.waddr = in_ch.trb_index;
              mreq.wdata = decode_trb(in_ch.control_word, in_ch.status_word);
            end
            FUNC_WALK: begin
              if (in_ch.trb_index == in_ch.enqueue_index) begin
                res_idx_nxt = in_ch.trb_index;
                res_sf_nxt  = in_ch.shortfall_in;
                state_nxt   = ST_DONE;
              end else begin
                mreq.re   = 1'b1;
                mreq.raddr = in_ch.trb_index;
                oob_nxt   = !({1'b0, in_ch.trb_index} < SIZE_CAP);
                cur_nxt   = in_ch.trb_index;
                enq_nxt   = in_ch.enqueue_index;
                sf_nxt    = in_ch.shortfall_in;
                steps_nxt = '0;
                add_nxt   = 1'b0;
                state_nxt = ST_WALK;
              end
            end
            FUNC_DEQ: begin
              res_sf_nxt = '0;
              if (in_nxt9 >= size_m1) begin
                res_idx_nxt = '0;
                state_nxt   = ST_DONE;
              end else if (in_nxt9[IDX_W-1:0] == in_ch.enqueue_index) begin
                res_idx_nxt = in_nxt9[IDX_W-1:0];
                state_nxt   = ST_DONE;
              end else begin
                mreq.re    = 1'b1;
                mreq.raddr = in_nxt9[IDX_W-1:0];
                oob_nxt    = !(in_nxt9 < SIZE_CAP);
                cur_nxt    = in_nxt9[IDX_W-1:0];
                state_nxt  = ST_DEQ;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        // advance one chained descriptor per cycle
        if (walk_cont && walk_nxt != enq_r) begin
          mreq.re    = 1'b1;
          mreq.raddr = walk_nxt;
          oob_nxt    = !({1'b0, walk_nxt} < SIZE_CAP);
          cur_nxt    = walk_nxt;
          steps_nxt  = steps_r + 9'd1;
          add_nxt    = 1'b1;
          sf_nxt     = sf_cur;
        end else begin
          res_idx_nxt = cur_r;
          res_sf_nxt  = sf_cur;
          state_nxt   = ST_DONE;
        end
      end
      ST_DEQ: begin
        res_idx_nxt = (rd_type == TYPE_LINK) ? '0 : cur_r;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output stage frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_sf_nxt    = res_sf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ring_size_r <= RING_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_size_r <= ring_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_idx_r <= out_idx_nxt;
    out_sf_r  <= out_sf_nxt;
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    enq_r     <= enq_nxt;
    sf_r      <= sf_nxt;
    steps_r   <= steps_nxt;
    add_r     <= add_nxt;
    oob_r     <= oob_nxt;
    res_idx_r <= res_idx_nxt;
    res_sf_r  <= res_sf_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_index  = out_idx_r;
  assign out_ch.shortfall_out = out_sf_r;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> steps_r <= size_eff)
    else $error("walk step count exceeds ring size");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.we && mreq.re))
    else $error("descriptor write and read issued together");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.func == FUNC_WRITE |=> state_r == ST_IDLE && !$rose(out_valid_r))
    else $error("descriptor write produced a result or left idle");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=>
      out_valid_r && out_idx_r == $past(res_idx_r) && out_sf_r == $past(res_sf_r))
    else $error("result not moved into output stage");

  a_walk_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_free |=> state_r == ST_DONE)
    else $error("pending result dropped while output stalled");
`endif

endmodule

[test/td_walk_checker.sv]
module td_walk_checker import twr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  twr_in_if    in_mon,
  twr_out_if   out_mon,
  twr_cfg_if   cfg_mon,
  output int   mismatches,
  output int   answers_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]  last_index;
    logic [WORD_W-1:0] shortfall;
  } td_answer_t;

  logic [KIND_W-1:0]  kind_mem  [256];
  logic [BYTES_W-1:0] bytes_mem [256];
  logic [SIZE_W-1:0]  ring_size_q = RING_SIZE_RST;
  td_answer_t         answer_q [$];

  function automatic int ring_span();
    int s;
    s = int'(ring_size_q);
    if (s < 2) s = 2;
    if (s > IDX_LIMIT) s = IDX_LIMIT;
    if (s > MAX_RING_ENTRIES_DEF) s = MAX_RING_ENTRIES_DEF;
    return s;
  endfunction

  // Follow the chain from start; bytes count only for normal slots stepped onto.
  function automatic td_answer_t walk_td(int start, int enq, logic [WORD_W-1:0] sf_in);
    int                 pos;
    int                 nxt;
    int                 span;
    int                 steps;
    logic [KIND_W-1:0]  k;
    logic [WORD_W-1:0]  sf;
    td_answer_t         a;
    span = ring_span();
    pos  = start;
    sf   = sf_in;
    if (pos != enq) begin
      k     = kind_mem[pos];
      steps = 0;
      while (k[KIND_W-1:1] != TYPE_EVENT_DATA && k[0] && steps < span) begin
        nxt = pos + 1;
        if (k[KIND_W-1:1] == TYPE_LINK || nxt >= span - 1) nxt = 0;
        if (nxt == enq) break;
        pos = nxt;
        k   = kind_mem[pos];
        if (k[KIND_W-1:1] == TYPE_NORMAL) sf = sf + WORD_W'(bytes_mem[pos]);
        steps++;
      end
    end
    a.last_index = IDX_W'(pos);
    a.shortfall  = sf;
    return a;
  endfunction

  function automatic td_answer_t next_dequeue(int start, int enq);
    int         nxt;
    int         span;
    td_answer_t a;
    span = ring_span();
    nxt  = start + 1;
    if (nxt >= span - 1) begin
      nxt = 0;
    end else if (nxt != enq && kind_mem[nxt][KIND_W-1:1] == TYPE_LINK) begin
      nxt = 0;
    end
    a.last_index = IDX_W'(nxt);
    a.shortfall  = '0;
    return a;
  endfunction

  always @(posedge clk) begin
    td_answer_t want;
    if (!rst_n) begin
      answer_q.delete();
      ring_size_q = RING_SIZE_RST;
      mismatches  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) ring_size_q = cfg_mon.ring_size;
      // pop before push: a result never belongs to the item accepted on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d shortfall %h",
                     out_mon.result_index, out_mon.shortfall_out);
        end else begin
          want = answer_q.pop_front();
          if (out_mon.result_index !== want.last_index ||
              out_mon.shortfall_out !== want.shortfall) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected index %0d shortfall %h, got index %0d shortfall %h",
                       want.last_index, want.shortfall,
                       out_mon.result_index, out_mon.shortfall_out);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (func_t'(in_mon.func))
          FUNC_WRITE: begin
            kind_mem[in_mon.trb_index]  = {in_mon.control_word[15:10], in_mon.control_word[4]};
            bytes_mem[in_mon.trb_index] = in_mon.status_word[BYTES_W-1:0];
          end
          FUNC_WALK: answer_q.push_back(walk_td(int'(in_mon.trb_index),
                                                int'(in_mon.enqueue_index),
                                                in_mon.shortfall_in));
          FUNC_DEQ:  answer_q.push_back(next_dequeue(int'(in_mon.trb_index),
                                                     int'(in_mon.enqueue_index)));
          default: ;
        endcase
      end
    end
    answers_owed = answer_q.size();
  end

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import twr_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int PHASES       = 10;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int WRITE_SETTLE = 16;
  localparam int SETTLE       = 300;

  logic clk = 1'b0;
  logic rst_n;

  twr_in_if  in_ch ();
  twr_out_if out_ch ();
  twr_cfg_if cfg_ch ();

  int fail_count;
  int owed;

  transfer_ring_td_walker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  td_walk_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .mismatches   (fail_count),
    .answers_owed (owed)
  );

  int          burst_left = 0;
  int          items_sent = 0;
  int          cycles     = 0;
  int          span       = 256;
  int          pat_left   = 0;
  logic [3:0]  pat_pos    = '0;
  logic [15:0] stall_pat  = '1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL transfer_ring_td_walker_top");
      $finish;
    end
  end

  // Receiver: ready follows a 16-bit stall pattern, redrawn when pat_left runs out; some patterns are stall-free.
  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left  = 64;
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end
    pat_left--;
    out_ch.ready <= stall_pat[pat_pos];
    pat_pos++;
  end

  function automatic int step_slot(int p);
    return (p + 1 >= span - 1) ? 0 : p + 1;
  endfunction

  function automatic logic [WORD_W-1:0] make_ctrl(logic [TYPE_W-1:0] t, logic ch);
    logic [WORD_W-1:0] w;
    w        = $urandom();
    w[15:10] = t;
    w[4]     = ch;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send(input func_t f, input logic [IDX_W-1:0] idx,
                      input logic [WORD_W-1:0] ctrl, input logic [WORD_W-1:0] stat,
                      input logic [IDX_W-1:0] enq, input logic [WORD_W-1:0] sf);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.trb_index     <= idx;
    in_ch.control_word  <= ctrl;
    in_ch.status_word   <= stat;
    in_ch.enqueue_index <= enq;
    in_ch.shortfall_in  <= sf;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (f != FUNC_UNUSED) items_sent++;
  endtask

  task automatic put_trb(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] ctrl,
                         input logic [WORD_W-1:0] stat);
    send(FUNC_WRITE, idx, ctrl, stat, IDX_W'($urandom()), $urandom());
  endtask

  task automatic walk_from(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] enq,
                           input logic [WORD_W-1:0] sf);
    send(FUNC_WALK, idx, $urandom(), $urandom(), enq, sf);
  endtask

  task automatic dequeue_from(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] enq);
    send(FUNC_DEQ, idx, $urandom(), $urandom(), enq, $urandom());
  endtask

  task automatic send_unused();
    send(FUNC_UNUSED, IDX_W'($urandom()), $urandom(), $urandom(), IDX_W'($urandom()),
         $urandom());
  endtask

  // Hold the sender until every result is back, then let trailing writes finish.
  task automatic wait_ring_idle();
    in_ch.valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
  endtask

  task automatic set_ring_size(input int v);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.ring_size <= SIZE_W'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    span = v & ((1 << SIZE_W) - 1);
    if (span < 2) span = 2;
    if (span > IDX_LIMIT) span = IDX_LIMIT;
  endtask

  // Lay down one TD: chained normals with optional links or other chained types, closed by
  // an unchained normal or a chained event-data entry.
  task automatic build_td(input int start, input int len, output int tail);
    int                p;
    logic [TYPE_W-1:0] t;
    logic              ch;
    logic [WORD_W-1:0] stat;
    p = start;
    for (int i = 0; i < len; i++) begin
      stat = $urandom();
      if ($urandom_range(0, 7) == 0) stat[BYTES_W-1:0] = '1;
      if (i == len - 1) begin
        if ($urandom_range(0, 3) == 0) begin
          t  = TYPE_EVENT_DATA;
          ch = 1'b1;
        end else begin
          t  = TYPE_NORMAL;
          ch = 1'b0;
        end
      end else if ($urandom_range(0, 9) == 0) begin
        t  = TYPE_LINK;
        ch = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        t  = TYPE_W'($urandom_range(2, 5));
        ch = 1'b1;
      end else begin
        t  = TYPE_NORMAL;
        ch = 1'b1;
      end
      put_trb(IDX_W'(p), make_ctrl(t, ch), stat);
      p = (t == TYPE_LINK) ? 0 : step_slot(p);
    end
    tail = p;
  endtask

  task automatic random_step();
    int r;
    int start;
    int tail;
    int enq;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      start = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
      build_td(start, $urandom_range(1, 6), tail);
      case ($urandom_range(0, 4))
        0:       enq = tail;
        1:       enq = start;
        2:       enq = step_slot(start);
        3:       enq = $urandom_range(0, 255);
        default: enq = step_slot(tail);
      endcase
      walk_from(IDX_W'(start), IDX_W'(enq), $urandom());
      if ($urandom_range(0, 2) == 0) dequeue_from(IDX_W'(start), IDX_W'(enq));
    end else if (r < 65) begin
      start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
      enq   = $urandom_range(0, 1) ? start + 1 : $urandom_range(0, 255);
      dequeue_from(IDX_W'(start), IDX_W'(enq));
    end else if (r < 80) begin
      start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
      walk_from(IDX_W'(start), IDX_W'($urandom()), $urandom());
    end else if (r < 95) begin
      put_trb(IDX_W'($urandom()), $urandom(), $urandom());
    end else begin
      send_unused();
    end
  endtask

  initial begin
    int                plan [9];
    int                phase_end;
    int                pick;
    logic [TYPE_W-1:0] t;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_WRITE;
    in_ch.trb_index     = '0;
    in_ch.control_word  = '0;
    in_ch.status_word   = '0;
    in_ch.enqueue_index = '0;
    in_ch.shortfall_in  = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.ring_size    = RING_SIZE_RST;
    out_ch.ready        = 1'b0;
    plan    = '{2, 0, 511, 1, 300, 255, 16, 3, 257};
    plan[7] = $urandom_range(3, 254);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill every slot so no query ever reads an unwritten descriptor.
    for (int i = 0; i < 256; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       t = TYPE_NORMAL;
      else if (pick == 6) t = TYPE_EVENT_DATA;
      else if (pick == 7) t = TYPE_LINK;
      else                t = TYPE_W'($urandom());
      put_trb(IDX_W'(i), make_ctrl(t, 1'($urandom())), $urandom());
    end

    // Directed cases at the reset ring size.
    put_trb(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_trb(8'd255, 32'h0, 32'h0);
    walk_from(8'd0, 8'd9, 32'h0);
    dequeue_from(8'd255, 8'd0);
    walk_from(8'd5, 8'd5, 32'hFFFF_FFFF);
    put_trb(8'd10, make_ctrl(TYPE_NORMAL, 1'b1), 32'hFFFF_FFFF);
    put_trb(8'd11, make_ctrl(TYPE_NORMAL, 1'b1), 32'h0001_FFFF);
    put_trb(8'd12, make_ctrl(TYPE_EVENT_DATA, 1'b1), $urandom());
    walk_from(8'd10, 8'd200, 32'hFFFF_FFFF);
    walk_from(8'd10, 8'd11, 32'h0000_1234);
    put_trb(8'd250, make_ctrl(TYPE_LINK, 1'b1), $urandom());
    put_trb(8'd0, make_ctrl(TYPE_NORMAL, 1'b0), 32'h0001_0000);
    walk_from(8'd250, 8'd100, 32'h0);
    dequeue_from(8'd249, 8'd3);
    dequeue_from(8'd249, 8'd250);
    dequeue_from(8'd254, 8'd0);
    send_unused();
    put_trb(8'd20, make_ctrl(TYPE_NORMAL, 1'b0), $urandom());
    walk_from(8'd20, 8'd0, 32'h0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_ring_idle();
        set_ring_size(plan[ph-1]);
        if (plan[ph-1] == 2) begin
          // endless chain: both slots chained normals, the walk runs out of steps
          put_trb(8'd0, make_ctrl(TYPE_NORMAL, 1'b1), $urandom());
          put_trb(8'd1, make_ctrl(TYPE_NORMAL, 1'b1), $urandom());
          walk_from(8'd0, 8'd200, 32'hFFFF_FFF0);
          walk_from(8'd1, 8'd0, $urandom());
        end
      end
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) random_step();
    end

    wait_ring_idle();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && owed == 0)
      $display("PASS transfer_ring_td_walker_top");
    else
      $display("FAIL transfer_ring_td_walker_top");
    $finish;
  end

endmodule
